[rtl/ple_pkg.sv]
// shared constants, codes and the cell control word for the positional list engine
package ple_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 8;
    localparam int COUNT_W      = 5;
    localparam int FUNC_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int CAPACITY_DEF = 16;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    typedef struct packed {
        logic              shift_up;
        logic              shift_down;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } cell_ctl_t;

endpackage

[rtl/positional_list_engine_top.sv]
// positional list engine: row of shifting cells plus count and result register
//
//  channel | handshake            | word
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | func, position, value
//  out     | out_valid / out_ready| read_value, count, is_empty, status
//
// one word per cycle while in_ready is high: the whole row of cells shifts in the accept
// cycle and the result lands in the output register on the same edge
// out_valid rises in the cycle after the input word is accepted
// in_ready stays high while the output register is empty or being drained
// reset clears the entry count and the output valid; cell contents are not reset
module positional_list_engine_top #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ple_pkg::FUNC_W-1:0]   func,
    input  logic [ple_pkg::POS_W-1:0]    position,
    input  logic signed [ple_pkg::DATA_W-1:0] value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [ple_pkg::DATA_W-1:0] read_value,
    output logic [ple_pkg::COUNT_W-1:0]  count,
    output logic                         is_empty,
    output logic [ple_pkg::STATUS_W-1:0] status
);
    import ple_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                out_valid_reg;
    logic [DATA_W-1:0]   read_value_reg;
    logic [DATA_W-1:0]   read_value_next;
    logic [COUNT_W-1:0]  count_out_reg;
    logic                is_empty_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;

    logic              accept;
    logic              full;
    logic [CMP_W-1:0]  pos_w;
    logic [CMP_W-1:0]  cnt_w;
    logic              in_range;
    logic              insert_ok;
    logic              delete_ok;
    logic              read_ok;
    logic [POS_W-1:0]  ins_pos;
    logic [DATA_W-1:0] rd_bus;
    cell_ctl_t         ctl;

    logic [DATA_W-1:0] cell_data [CAPACITY];
    logic [DATA_W-1:0] cell_tap  [CAPACITY];

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign full     = (count_reg == CAP_CNT);
    assign pos_w    = CMP_W'(position);
    assign cnt_w    = CMP_W'(count_reg);
    assign in_range = (pos_w < cnt_w);

    // past the end an insert becomes an append at the current count
    assign ins_pos   = (pos_w > cnt_w) ? POS_W'(cnt_w) : position;
    assign insert_ok = accept && (func == FUNC_INSERT) && !full;
    assign delete_ok = accept && (func == FUNC_DELETE) && in_range;
    assign read_ok   = (func == FUNC_READ) && in_range;

    always_comb
    begin
        ctl.shift_up   = insert_ok;
        ctl.shift_down = delete_ok;
        ctl.pos        = (func == FUNC_INSERT) ? ins_pos : position;
        ctl.value      = value;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [DATA_W-1:0] left_d;
            logic [DATA_W-1:0] right_d;

            if (gi == 0)
            begin : g_first
                assign left_d = '0;
            end
            else
            begin : g_mid_l
                assign left_d = cell_data[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_d = '0;
            end
            else
            begin : g_mid_r
                assign right_d = cell_data[gi+1];
            end

            ple_cell #(
                .IDX (gi)
            ) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[gi]),
                .tap        (cell_tap[gi])
            );
        end
    endgenerate

    // at most one cell matches, so the taps combine by or
    always_comb
    begin
        rd_bus = '0;
        for (int i = 0; i < CAPACITY; i++)
            rd_bus = rd_bus | cell_tap[i];
    end

    always_comb
    begin
        count_next      = count_reg;
        status_next     = STATUS_OK;
        read_value_next = '0;
        unique case (func)
            FUNC_INSERT:
            begin
                if (full)
                    status_next = STATUS_FULL;
                else
                    count_next = count_reg + CNT_W'(1);
            end
            FUNC_DELETE:
            begin
                if (in_range)
                    count_next = count_reg - CNT_W'(1);
                else
                    status_next = STATUS_RANGE;
            end
            FUNC_READ:
            begin
                if (read_ok)
                    read_value_next = rd_bus;
                else
                    status_next = STATUS_RANGE;
            end
            default:
            begin
                status_next = STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_value_reg <= read_value_next;
            count_out_reg  <= COUNT_W'(count_next);
            is_empty_reg   <= (count_next == '0);
            status_reg     <= status_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign count      = count_out_reg;
    assign is_empty   = is_empty_reg;
    assign status     = status_reg;

endmodule

[rtl/ple_cell.sv]
// one list slot: holds an entry, shifts with its neighbors, taps out on a position match
module ple_cell #(
    parameter int IDX = 0
) (
    input  logic                    clk,
    input  ple_pkg::cell_ctl_t      ctl,
    input  logic [ple_pkg::DATA_W-1:0] left_data,
    input  logic [ple_pkg::DATA_W-1:0] right_data,
    output logic [ple_pkg::DATA_W-1:0] data,
    output logic [ple_pkg::DATA_W-1:0] tap
);
    import ple_pkg::*;

    localparam logic [POS_W-1:0] IDX_P = POS_W'(IDX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.shift_up)
        begin
            if (IDX_P == ctl.pos)
                data_next = ctl.value;
            else if (IDX_P > ctl.pos)
                data_next = left_data;
        end
        else if (ctl.shift_down)
        begin
            if (IDX_P >= ctl.pos)
                data_next = right_data;
        end
    end

    // entries are payload: written before they are ever read
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign tap  = (IDX_P == ctl.pos) ? data_reg : '0;

endmodule

[dv/tb.sv]
// testbench for the positional list engine: directed table, random list traffic, self-check
module tb;
    import ple_pkg::*;

    localparam int          CYCLE_LIMIT = 200000;
    localparam int          RANDOM_WORDS = 450;
    localparam int          DIR_ROWS = 19;
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [DATA_W-1:0]   rd;
        logic [COUNT_W-1:0]  cnt;
        logic                empty;
        logic [STATUS_W-1:0] st;
    } list_result_t;

    typedef struct packed {
        logic [FUNC_W-1:0] fn;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
        logic [4:0]        reps;
        logic              typed;
        list_result_t      want;
    } dir_row_t;

    // rows with typed set carry their result, the rest go through the list model
    localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
        '{FUNC_READ,   8'd0,   32'd0,          5'd1,  1'b1, '{32'd0, 5'd0,  1'b1, STATUS_RANGE}},
        '{FUNC_DELETE, 8'd0,   32'd0,          5'd1,  1'b1, '{32'd0, 5'd0,  1'b1, STATUS_RANGE}},
        '{FUNC_SPARE,  8'd255, 32'hFFFF_FFFF,  5'd1,  1'b1, '{32'd0, 5'd0,  1'b1, STATUS_OK}},
        '{FUNC_INSERT, 8'd255, VAL_MIN,        5'd1,  1'b1, '{32'd0, 5'd1,  1'b0, STATUS_OK}},
        '{FUNC_INSERT, 8'd0,   VAL_MAX,        5'd1,  1'b1, '{32'd0, 5'd2,  1'b0, STATUS_OK}},
        '{FUNC_INSERT, 8'd1,   32'd0,          5'd1,  1'b0, '0},
        '{FUNC_READ,   8'd0,   32'd0,          5'd1,  1'b1, '{VAL_MAX, 5'd3, 1'b0, STATUS_OK}},
        '{FUNC_READ,   8'd2,   32'hFFFF_FFFF,  5'd1,  1'b1, '{VAL_MIN, 5'd3, 1'b0, STATUS_OK}},
        '{FUNC_READ,   8'd1,   32'd0,          5'd1,  1'b0, '0},
        '{FUNC_READ,   8'd3,   32'd0,          5'd1,  1'b1, '{32'd0, 5'd3,  1'b0, STATUS_RANGE}},
        '{FUNC_READ,   8'd255, 32'd0,          5'd1,  1'b1, '{32'd0, 5'd3,  1'b0, STATUS_RANGE}},
        '{FUNC_DELETE, 8'd3,   32'd0,          5'd1,  1'b1, '{32'd0, 5'd3,  1'b0, STATUS_RANGE}},
        '{FUNC_DELETE, 8'd1,   32'd0,          5'd1,  1'b1, '{32'd0, 5'd2,  1'b0, STATUS_OK}},
        // fill to capacity by inserting between the two end words
        '{FUNC_INSERT, 8'd1,   32'h5555_5555,  5'd14, 1'b0, '0},
        '{FUNC_INSERT, 8'd0,   32'hAAAA_AAAA,  5'd1,  1'b1, '{32'd0, 5'd16, 1'b0, STATUS_FULL}},
        '{FUNC_INSERT, 8'd255, 32'h1234_5678,  5'd1,  1'b1, '{32'd0, 5'd16, 1'b0, STATUS_FULL}},
        '{FUNC_READ,   8'd15,  32'd0,          5'd1,  1'b1, '{VAL_MIN, 5'd16, 1'b0, STATUS_OK}},
        '{FUNC_READ,   8'd16,  32'd0,          5'd1,  1'b1, '{32'd0, 5'd16, 1'b0, STATUS_RANGE}},
        '{FUNC_DELETE, 8'd15,  32'd0,          5'd1,  1'b1, '{32'd0, 5'd15, 1'b0, STATUS_OK}}
    };

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [FUNC_W-1:0]   func;
    logic [POS_W-1:0]    position;
    logic [DATA_W-1:0]   value;
    logic                out_valid;
    logic                out_ready;
    logic [DATA_W-1:0]   read_value;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
    logic [STATUS_W-1:0] status;

    // list model state
    logic [DATA_W-1:0]   list_mem [CAPACITY_DEF];
    int                  list_len;

    list_result_t        pending_results [$];
    int                  mismatch_cnt;
    int                  cycle_cnt;
    int                  burst_left;

    positional_list_engine_top #(
        .CAPACITY (CAPACITY_DEF)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .position   (position),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_value (read_value),
        .count      (count),
        .is_empty   (is_empty),
        .status     (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic list_result_t list_apply(input logic [FUNC_W-1:0] fn,
                                                input logic [POS_W-1:0] pos,
                                                input logic [DATA_W-1:0] val);
        list_result_t r;
        int           at;
        r       = '0;
        r.st    = STATUS_OK;
        at      = int'(pos);
        case (fn)
            FUNC_INSERT:
            begin
                if (list_len >= CAPACITY_DEF)
                    r.st = STATUS_FULL;
                else
                begin
                    if (at > list_len)
                        at = list_len;
                    for (int i = list_len; i > at; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[at] = val;
                    list_len++;
                end
            end
            FUNC_DELETE:
            begin
                if (at >= list_len)
                    r.st = STATUS_RANGE;
                else
                begin
                    for (int i = at; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            FUNC_READ:
            begin
                if (at >= list_len)
                    r.st = STATUS_RANGE;
                else
                    r.rd = list_mem[at];
            end
            default: ;
        endcase
        r.cnt   = list_len[COUNT_W-1:0];
        r.empty = (list_len == 0);
        return r;
    endfunction

    // one word through the input channel, with bursts and gaps in between
    task automatic send_word(input logic [FUNC_W-1:0] fn, input logic [POS_W-1:0] pos,
                             input logic [DATA_W-1:0] val, input logic typed,
                             input list_result_t want);
        int           gap;
        list_result_t predicted;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        in_valid <= 1'b1;
        func     <= fn;
        position <= pos;
        value    <= val;
        // in_ready is settled by the falling edge and holds until the next rising one
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        predicted = list_apply(fn, pos, val);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // receiver back-pressure: switches at random between four ready modes
    initial
    begin : ready_gen
        int mode;
        int mode_left;
        int phase;
        logic rdy;
        mode_left = 0;
        phase     = 0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            phase++;
            case (mode)
                0: rdy = 1'b1;
                1: rdy = ($urandom_range(0, 3) != 0);
                2: rdy = ((phase % 3) != 0);
                default: rdy = ($urandom_range(0, 7) == 0);
            endcase
            out_ready <= rdy;
        end
    end

    // result words are compared on the falling edge before the edge that takes them
    always @(negedge clk)
    begin : result_check
        list_result_t got;
        list_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{read_value, count, is_empty, status};
            if (pending_results.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display({"unexpected result word: read_value %h count %0d",
                              " is_empty %0b status %0d"},
                             got.rd, got.cnt, got.empty, got.st);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.rd !== want.rd || got.cnt !== want.cnt ||
                    got.empty !== want.empty || got.st !== want.st)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display({"result mismatch: read_value %h/%h count %0d/%0d",
                                  " is_empty %0b/%0b status %0d/%0d (exp/got)"},
                                 want.rd, got.rd, want.cnt, got.cnt,
                                 want.empty, got.empty, want.st, got.st);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin : stimulus
        int           k;
        int           drift;
        int           drift_left;
        int           hi;
        logic [FUNC_W-1:0] fn;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
        mismatch_cnt = 0;
        cycle_cnt    = 0;
        burst_left   = 0;
        list_len     = 0;
        drift_left   = 0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        func     <= FUNC_READ;
        position <= '0;
        value    <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[r])
            for (int n = 0; n < DIRECTED_ROWS[r].reps; n++)
                send_word(DIRECTED_ROWS[r].fn, DIRECTED_ROWS[r].pos,
                          DIRECTED_ROWS[r].val + n, DIRECTED_ROWS[r].typed,
                          DIRECTED_ROWS[r].want);

        for (int w = 0; w < RANDOM_WORDS; w++)
        begin
            // drift between growing, shrinking and mixed traffic so the list hits both ends
            if (drift_left == 0)
            begin
                drift      = $urandom_range(0, 2);
                drift_left = $urandom_range(20, 60);
            end
            drift_left--;
            k = $urandom_range(0, 99);
            if (k < 4)
                fn = FUNC_SPARE;
            else if (k < ((drift == 0) ? 64 : (drift == 1) ? 19 : 36))
                fn = FUNC_INSERT;
            else if (k < ((drift == 0) ? 79 : (drift == 1) ? 79 : 68))
                fn = FUNC_DELETE;
            else
                fn = FUNC_READ;

            k = $urandom_range(0, 9);
            hi = (fn == FUNC_INSERT) ? list_len : list_len - 1;
            if (k == 0)
                pos = POS_W'($urandom_range(0, 255));
            else if (k == 1)
                pos = ($urandom_range(0, 1) == 0) ? 8'd255 : list_len[POS_W-1:0];
            else if (hi <= 0)
                pos = '0;
            else
                pos = POS_W'($urandom_range(0, hi));

            k = $urandom_range(0, 9);
            case (k)
                0: val = VAL_MIN;
                1: val = VAL_MAX;
                2: val = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFF_FFFF;
                default: val = $urandom;
            endcase
            send_word(fn, pos, val, 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[filelist.f]
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/positional_list_engine_top.sv
dv/tb.sv
